### design/udfe_pkg.sv
`default_nettype none

package udfe_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ACT_W = 3;
    localparam int unsigned LEVEL_W = 9;
    localparam int unsigned TONE_W = 16;
    localparam int unsigned TONE_SHIFT = 8;

    localparam logic [BYTE_W-1:0] BREAK_CODE = 8'h03;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUSH_TX  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP_RX   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LINE_RX  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LINE_TX  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_BREAK_RD = 3'd4;

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage : udfe_pkg

`default_nettype wire

### design/udfe_ram.sv
`default_nettype none

module udfe_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW = 8
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [udfe_pkg::BYTE_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output logic      [udfe_pkg::BYTE_W-1:0] rdata
);
    import udfe_pkg::*;

    // byte store, one write and one registered read per cycle
    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : udfe_ram

`default_nettype wire

### design/uart_dual_fifo_with_echo.sv
`default_nettype none

// Two byte ring FIFOs between a host and a serial line, each FIFO_DEPTH bytes deep.
// An item is taken when start is high and busy is low; its result appears on the
// result ports in the next cycle with done high for exactly one cycle, and the
// receiver cannot hold it off. Every item has an accept cycle, which issues the read
// of the FIFO tail entry to the byte memory, and an execute cycle, in which the
// registered read data comes back, the pointers, levels and flags are updated, any
// write to the memories is made and the result is shown. busy is high during the
// execute cycle, so a new item cannot be started until it is over. A received byte
// that finds room in the receive FIFO is stored and echoed into the transmit FIFO;
// if the transmit FIFO is full, the echo is dropped and echo_dropped is raised. A
// received 0x03 that is stored sets a sticky break flag that the break read action
// returns and clears. Levels are reported on nine bits.
module uart_dual_fifo_with_echo #(
    parameter int unsigned FIFO_DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [udfe_pkg::ACT_W-1:0]    action,
    input  wire logic [udfe_pkg::BYTE_W-1:0]   data_byte,
    output logic                               done,
    output logic                               ok,
    output logic      [udfe_pkg::BYTE_W-1:0]   data_out,
    output logic      [udfe_pkg::LEVEL_W-1:0]  rx_level,
    output logic      [udfe_pkg::LEVEL_W-1:0]  tx_level,
    output logic                               rx_available,
    output logic                               break_seen,
    output logic                               tx_irq_on,
    output logic                               rx_irq_on,
    output logic                               echo_dropped,
    output logic      [udfe_pkg::TONE_W-1:0]   tone_duty
);
    import udfe_pkg::*;

    // pointer and fill widths follow the depth
    localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(FIFO_DEPTH);

    // sequencer state
    state_t state_reg, state_next;

    // captured item
    logic [ACT_W-1:0]  act_reg;
    logic [BYTE_W-1:0] byte_reg;

    // fifo pointers and fill counts
    logic [AW-1:0]     tx_head_reg, tx_head_next;
    logic [AW-1:0]     tx_tail_reg, tx_tail_next;
    logic [FILL_W-1:0] tx_fill_reg, tx_fill_next;
    logic [AW-1:0]     rx_head_reg, rx_head_next;
    logic [AW-1:0]     rx_tail_reg, rx_tail_next;
    logic [FILL_W-1:0] rx_fill_reg, rx_fill_next;

    // flags and tone value
    logic              break_reg, break_next;
    logic              tx_irq_reg, tx_irq_next;
    logic              rx_irq_reg, rx_irq_next;
    logic [TONE_W-1:0] tone_reg, tone_next;

    // memory ports
    logic              tx_we, rx_we;
    logic              tx_re, rx_re;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;

    logic accept;
    logic exec;

    assign accept = start && (state_reg == ST_IDLE);
    assign exec = (state_reg == ST_EXEC);
    assign busy = exec;
    assign done = exec;

    // the tail entry is read at accept time so its data is ready in the execute cycle
    assign tx_re = accept && (action == ACT_LINE_TX);
    assign rx_re = accept && (action == ACT_POP_RX);

    udfe_ram #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (byte_reg),
        .re    (tx_re),
        .raddr (tx_tail_reg),
        .rdata (tx_rdata)
    );

    udfe_ram #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (byte_reg),
        .re    (rx_re),
        .raddr (rx_tail_reg),
        .rdata (rx_rdata)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state: an accepted item moves to the execute state, which returns to idle
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // item capture, payload only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            byte_reg <= data_byte;
        end
    end

    // fifo control and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            tx_fill_reg <= '0;
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            rx_fill_reg <= '0;
            break_reg   <= 1'b0;
            tx_irq_reg  <= 1'b0;
            rx_irq_reg  <= 1'b1;
            tone_reg    <= '0;
        end
        else
        begin
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            tx_fill_reg <= tx_fill_next;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            rx_fill_reg <= rx_fill_next;
            break_reg   <= break_next;
            tx_irq_reg  <= tx_irq_next;
            rx_irq_reg  <= rx_irq_next;
            tone_reg    <= tone_next;
        end
    end

    // execute cycle: update pointers, levels and flags from the captured item and drive the result
    always_comb
    begin
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        tx_fill_next = tx_fill_reg;
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        rx_fill_next = rx_fill_reg;
        break_next   = break_reg;
        tx_irq_next  = tx_irq_reg;
        rx_irq_next  = rx_irq_reg;
        tone_next    = tone_reg;
        tx_we        = 1'b0;
        rx_we        = 1'b0;
        ok           = 1'b0;
        data_out     = '0;
        echo_dropped = 1'b0;

        if (exec)
        begin
            case (act_reg)
                ACT_PUSH_TX:
                begin
                    // host push, ignored when the transmit fifo is full
                    if (tx_fill_reg < FULL_FILL)
                    begin
                        tx_we        = 1'b1;
                        tx_head_next = (tx_head_reg == LAST_PTR) ? '0 : tx_head_reg + 1'b1;
                        tx_fill_next = tx_fill_reg + 1'b1;
                        tx_irq_next  = 1'b1;
                        ok           = 1'b1;
                    end
                end
                ACT_POP_RX:
                begin
                    // host pop from the receive fifo
                    if (rx_fill_reg != '0)
                    begin
                        data_out     = rx_rdata;
                        rx_tail_next = (rx_tail_reg == LAST_PTR) ? '0 : rx_tail_reg + 1'b1;
                        rx_fill_next = rx_fill_reg - 1'b1;
                        rx_irq_next  = 1'b1;
                        ok           = 1'b1;
                    end
                end
                ACT_LINE_RX:
                begin
                    // byte from the line: store, echo, break and tone
                    if (rx_fill_reg < FULL_FILL)
                    begin
                        if (byte_reg == BREAK_CODE)
                        begin
                            break_next = 1'b1;
                        end
                        if (tx_fill_reg < FULL_FILL)
                        begin
                            tx_we        = 1'b1;
                            tx_head_next = (tx_head_reg == LAST_PTR) ? '0
                                                                     : tx_head_reg + 1'b1;
                            tx_fill_next = tx_fill_reg + 1'b1;
                            tx_irq_next  = 1'b1;
                        end
                        else
                        begin
                            echo_dropped = 1'b1;
                        end
                        tone_next    = TONE_W'(byte_reg) << TONE_SHIFT;
                        rx_we        = 1'b1;
                        rx_head_next = (rx_head_reg == LAST_PTR) ? '0 : rx_head_reg + 1'b1;
                        rx_fill_next = rx_fill_reg + 1'b1;
                        ok           = 1'b1;
                    end
                    else
                    begin
                        // overrun: byte lost, receive interrupt turned off
                        rx_irq_next = 1'b0;
                    end
                end
                ACT_LINE_TX:
                begin
                    // line takes the next byte to send
                    if (tx_fill_reg != '0)
                    begin
                        data_out     = tx_rdata;
                        tx_tail_next = (tx_tail_reg == LAST_PTR) ? '0 : tx_tail_reg + 1'b1;
                        tx_fill_next = tx_fill_reg - 1'b1;
                        ok           = 1'b1;
                    end
                    else
                    begin
                        tx_irq_next = 1'b0;
                    end
                end
                ACT_BREAK_RD:
                begin
                    break_next = 1'b0;
                end
                default:
                begin
                    // unused codes only report status
                end
            endcase
        end
    end

    // status after the step; the break read returns the flag before clearing
    assign rx_level     = LEVEL_W'(rx_fill_next);
    assign tx_level     = LEVEL_W'(tx_fill_next);
    assign rx_available = (rx_fill_next != '0);
    assign break_seen   = (act_reg == ACT_BREAK_RD) ? break_reg : break_next;
    assign tx_irq_on    = tx_irq_next;
    assign rx_irq_on    = rx_irq_next;
    assign tone_duty    = tone_next;

`ifndef SYNTH
    // fill counts never pass the depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_fill_reg <= FULL_FILL) && (rx_fill_reg <= FULL_FILL))
        else $error("fifo fill count above depth");

    // every accepted item gives its result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted item without result");

    // busy always falls again in the next cycle
    a_one_exec: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // an echo is dropped only when the transmit fifo is full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && echo_dropped) |-> (tx_fill_reg == FULL_FILL) && ok)
        else $error("echo dropped with room in transmit fifo");
`endif

endmodule : uart_dual_fifo_with_echo

`default_nettype wire

### sim/testbench.sv
`default_nettype none

module testbench;

    import udfe_pkg::*;

    localparam int unsigned FIFO_DEPTH = 256;
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned SETTLE_CYCLES = 4;

    // action codes the block leaves unused, they only report status
    localparam logic [ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

    // everything the block reports for one item
    typedef struct packed {
        logic               ok;
        logic [BYTE_W-1:0]  data_out;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
        logic               rx_available;
        logic               break_seen;
        logic               tx_irq_on;
        logic               rx_irq_on;
        logic               echo_dropped;
        logic [TONE_W-1:0]  tone_duty;
    } uart_status_t;

    // one row of the directed part, typed marks rows whose status is written out
    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [BYTE_W-1:0] data_val;
        logic              typed;
        uart_status_t      want;
    } directed_row_t;

    typedef enum int
    {
        MIX_TRAFFIC,
        FILL_TRAFFIC,
        DRAIN_TRAFFIC
    } traffic_t;

    localparam uart_status_t NO_STATUS = '0;
    localparam int unsigned DIRECTED_COUNT = 26;

    // status right after reset is all zero except the receive interrupt enable
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // empty fifos: pop, send request, break read and spare codes all fail
        '{ACT_POP_RX,    8'h00, 1'b1, '{1'b0, 8'h00, 9'd0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000}},
        '{ACT_LINE_TX,   8'h00, 1'b1, '{1'b0, 8'h00, 9'd0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000}},
        '{ACT_BREAK_RD,  8'h00, 1'b1, '{1'b0, 8'h00, 9'd0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000}},
        '{ACT_SPARE_LO,  8'hFF, 1'b1, '{1'b0, 8'h00, 9'd0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000}},
        '{ACT_SPARE_HI,  8'h00, 1'b1, '{1'b0, 8'h00, 9'd0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000}},
        // host push then line send of the same byte
        '{ACT_PUSH_TX,   8'hFF, 1'b1, '{1'b1, 8'h00, 9'd0, 9'd1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000}},
        '{ACT_LINE_TX,   8'h00, 1'b1, '{1'b1, 8'hFF, 9'd0, 9'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000}},
        // break byte: stored, echoed, flag set, tone follows
        '{ACT_LINE_RX,   BREAK_CODE, 1'b1, '{1'b1, 8'h00, 9'd1, 9'd1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0300}},
        // first read returns the flag, second sees it cleared
        '{ACT_BREAK_RD,  8'h00, 1'b1, '{1'b0, 8'h00, 9'd1, 9'd1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0300}},
        '{ACT_BREAK_RD,  8'h00, 1'b1, '{1'b0, 8'h00, 9'd1, 9'd1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0300}},
        // rest of the directed rows go through the predictor
        '{ACT_LINE_RX,   8'hFF, 1'b0, NO_STATUS},
        '{ACT_LINE_RX,   8'h00, 1'b0, NO_STATUS},
        '{ACT_PUSH_TX,   8'h00, 1'b0, NO_STATUS},
        '{ACT_PUSH_TX,   8'h80, 1'b0, NO_STATUS},
        '{ACT_SPARE_MID, 8'hAA, 1'b0, NO_STATUS},
        '{ACT_POP_RX,    8'h5A, 1'b0, NO_STATUS},
        '{ACT_POP_RX,    8'hA5, 1'b0, NO_STATUS},
        '{ACT_POP_RX,    8'hFF, 1'b0, NO_STATUS},
        '{ACT_POP_RX,    8'h00, 1'b0, NO_STATUS},
        '{ACT_LINE_TX,   8'h5A, 1'b0, NO_STATUS},
        '{ACT_LINE_TX,   8'hA5, 1'b0, NO_STATUS},
        '{ACT_LINE_TX,   8'hFF, 1'b0, NO_STATUS},
        '{ACT_LINE_TX,   8'h00, 1'b0, NO_STATUS},
        '{ACT_LINE_TX,   8'h33, 1'b0, NO_STATUS},
        '{ACT_LINE_TX,   8'hCC, 1'b0, NO_STATUS},
        '{ACT_PUSH_TX,   8'h55, 1'b0, NO_STATUS}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [ACT_W-1:0]    action = ACT_PUSH_TX;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                busy;
    logic                done;
    logic                ok;
    logic [BYTE_W-1:0]   data_out;
    logic [LEVEL_W-1:0]  rx_level;
    logic [LEVEL_W-1:0]  tx_level;
    logic                rx_available;
    logic                break_seen;
    logic                tx_irq_on;
    logic                rx_irq_on;
    logic                echo_dropped;
    logic [TONE_W-1:0]   tone_duty;

    uart_dual_fifo_with_echo #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .data_byte(data_byte),
        .done(done),
        .ok(ok),
        .data_out(data_out),
        .rx_level(rx_level),
        .tx_level(tx_level),
        .rx_available(rx_available),
        .break_seen(break_seen),
        .tx_irq_on(tx_irq_on),
        .rx_irq_on(rx_irq_on),
        .echo_dropped(echo_dropped),
        .tone_duty(tone_duty)
    );

    always #5 clk = ~clk;

    // shadow copy of both rings and the status flags
    logic [BYTE_W-1:0] tx_ring [FIFO_DEPTH];
    logic [BYTE_W-1:0] rx_ring [FIFO_DEPTH];
    int unsigned       tx_wr_ptr = 0;
    int unsigned       tx_rd_ptr = 0;
    int unsigned       tx_count = 0;
    int unsigned       rx_wr_ptr = 0;
    int unsigned       rx_rd_ptr = 0;
    int unsigned       rx_count = 0;
    logic              break_pending = 1'b0;
    logic              tx_irq_shadow = 1'b0;
    logic              rx_irq_shadow = 1'b1;
    logic [TONE_W-1:0] tone_shadow = '0;

    // status words still owed by the block, oldest first
    uart_status_t      owed_status [$];
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       sender_idle_pct = 25;

    function automatic int unsigned next_slot(input int unsigned p);
        return (p + 1 >= FIFO_DEPTH) ? 0 : p + 1;
    endfunction

    // push into the transmit ring, shared by host pushes and the receive echo
    function automatic logic tx_ring_push(input logic [BYTE_W-1:0] val);
        if (tx_count >= FIFO_DEPTH)
            return 1'b0;
        tx_ring[tx_wr_ptr] = val;
        tx_wr_ptr = next_slot(tx_wr_ptr);
        tx_count++;
        tx_irq_shadow = 1'b1;
        return 1'b1;
    endfunction

    // advance the shadow state by one item and return the status it should show
    function automatic uart_status_t apply_uart_action(input logic [ACT_W-1:0] act,
                                                      input logic [BYTE_W-1:0] val);
        uart_status_t s;
        s = '0;
        case (act)
            ACT_PUSH_TX:
                s.ok = tx_ring_push(val);
            ACT_POP_RX:
                if (rx_count > 0)
                begin
                    s.data_out = rx_ring[rx_rd_ptr];
                    rx_rd_ptr = next_slot(rx_rd_ptr);
                    rx_count--;
                    rx_irq_shadow = 1'b1;
                    s.ok = 1'b1;
                end
            ACT_LINE_RX:
                if (rx_count < FIFO_DEPTH)
                begin
                    if (val == BREAK_CODE)
                        break_pending = 1'b1;
                    // byte is kept even when its echo finds no room
                    s.echo_dropped = !tx_ring_push(val);
                    tone_shadow = TONE_W'(val) << TONE_SHIFT;
                    rx_ring[rx_wr_ptr] = val;
                    rx_wr_ptr = next_slot(rx_wr_ptr);
                    rx_count++;
                    s.ok = 1'b1;
                end
                else
                begin
                    rx_irq_shadow = 1'b0;
                end
            ACT_LINE_TX:
                if (tx_count > 0)
                begin
                    s.data_out = tx_ring[tx_rd_ptr];
                    tx_rd_ptr = next_slot(tx_rd_ptr);
                    tx_count--;
                    s.ok = 1'b1;
                end
                else
                begin
                    tx_irq_shadow = 1'b0;
                end
            default:
                ;
        endcase
        // break read shows the flag before clearing it
        s.break_seen = break_pending;
        if (act == ACT_BREAK_RD)
            break_pending = 1'b0;
        s.rx_level = LEVEL_W'(rx_count);
        s.tx_level = LEVEL_W'(tx_count);
        s.rx_available = (rx_count > 0);
        s.tx_irq_on = tx_irq_shadow;
        s.rx_irq_on = rx_irq_shadow;
        s.tone_duty = tone_shadow;
        return s;
    endfunction

    // offer one item, with random idle cycles in front, and log what it should return;
    // called right after a rising edge so start changes only once per time step
    task automatic offer_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] val,
                              input logic typed, input uart_status_t typed_status);
        uart_status_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        data_byte <= val;
        // busy read here is its value before the edge, the one that decides
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_uart_action(act, val);
        owed_status.push_back(typed ? typed_status : predicted);
    endtask

    // hold the sender off until the block has answered everything
    task automatic wait_for_quiet();
        start <= 1'b0;
        do
            @(posedge clk);
        while (owed_status.size() != 0);
    endtask

    function automatic logic [ACT_W-1:0] pick_action(input traffic_t mode);
        int unsigned r;
        r = $urandom_range(99);
        case (mode)
            // mostly line bytes, so both rings run full and overflow
            FILL_TRAFFIC:
                if (r < 90)
                    return ACT_LINE_RX;
                else if (r < 96)
                    return ACT_PUSH_TX;
                else
                    return ACT_W'($urandom_range(ACT_POP_RX, ACT_SPARE_HI));
            // mostly reads from both rings
            DRAIN_TRAFFIC:
                if (r < 45)
                    return ACT_POP_RX;
                else if (r < 90)
                    return ACT_LINE_TX;
                else if (r < 94)
                    return ACT_BREAK_RD;
                else
                    return ACT_W'($urandom_range(ACT_PUSH_TX, ACT_SPARE_HI));
            default:
                if (r < 25)
                    return ACT_PUSH_TX;
                else if (r < 45)
                    return ACT_POP_RX;
                else if (r < 70)
                    return ACT_LINE_RX;
                else if (r < 90)
                    return ACT_LINE_TX;
                else if (r < 95)
                    return ACT_BREAK_RD;
                else
                    return ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        endcase
    endfunction

    // break code often, the byte extremes now and then, otherwise anything
    function automatic logic [BYTE_W-1:0] pick_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return BREAK_CODE;
        else if (r < 15)
            return '0;
        else if (r < 20)
            return '1;
        else
            return BYTE_W'($urandom_range(255));
    endfunction

    task automatic check_field(input string what, input logic [TONE_W-1:0] want,
                               input logic [TONE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // result checker, done is high for exactly one cycle per item
    always @(posedge clk)
    begin
        uart_status_t want;
        if (rst_n && done)
        begin
            if (owed_status.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, got ok=%0b data=0x%0h",
                         $time, ok, data_out);
                mismatch_count++;
            end
            else
            begin
                want = owed_status.pop_front();
                check_field("ok", TONE_W'(want.ok), TONE_W'(ok));
                check_field("data_out", TONE_W'(want.data_out), TONE_W'(data_out));
                check_field("rx_level", TONE_W'(want.rx_level), TONE_W'(rx_level));
                check_field("tx_level", TONE_W'(want.tx_level), TONE_W'(tx_level));
                check_field("rx_available", TONE_W'(want.rx_available),
                            TONE_W'(rx_available));
                check_field("break_seen", TONE_W'(want.break_seen), TONE_W'(break_seen));
                check_field("tx_irq_on", TONE_W'(want.tx_irq_on), TONE_W'(tx_irq_on));
                check_field("rx_irq_on", TONE_W'(want.rx_irq_on), TONE_W'(rx_irq_on));
                check_field("echo_dropped", TONE_W'(want.echo_dropped),
                            TONE_W'(echo_dropped));
                check_field("tone_duty", want.tone_duty, tone_duty);
            end
        end
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        traffic_t    plan_mode [3];
        int unsigned plan_len [3];
        int unsigned random_index;
        plan_mode = '{MIX_TRAFFIC, FILL_TRAFFIC, DRAIN_TRAFFIC};
        plan_len = '{60, 330, 150};
        random_index = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, sender idles a quarter of the time
        sender_idle_pct = 25;
        foreach (DIRECTED_ROWS[i])
            offer_item(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].data_val,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        wait_for_quiet();

        // random part: light traffic, then overflow both rings, then drain;
        // sender idle rate steps from 25 to 66 to none over the run
        for (int p = 0; p < 3; p++)
        begin
            for (int unsigned n = 0; n < plan_len[p]; n++)
            begin
                sender_idle_pct = (random_index < 180) ? 25 : (random_index < 360) ? 66 : 0;
                offer_item(pick_action(plan_mode[p]), pick_byte(), 1'b0, NO_STATUS);
                random_index++;
                // now and then let the block run dry in the middle of traffic
                if ($urandom_range(99) < 2)
                    wait_for_quiet();
            end
            wait_for_quiet();
        end

        start <= 1'b0;
        while (owed_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule : testbench

`default_nettype wire

### files.f
design/udfe_pkg.sv
design/udfe_ram.sv
design/uart_dual_fifo_with_echo.sv
sim/testbench.sv
